FILE: sv/clb_pkg.sv
`default_nettype none

package clb_pkg;

    // Default grid size and particle limit.
    localparam int CELLS_X_DEF       = 16;
    localparam int CELLS_Y_DEF       = 16;
    localparam int CELLS_Z_DEF       = 16;
    localparam int MAX_PARTICLES_DEF = 65536;

    // Field widths.
    localparam int NUM_AXES   = 3;
    localparam int POS_W      = 32;
    localparam int INV_W      = 32;
    localparam int BOUNDS_W   = 64;
    localparam int ID_W       = 16;
    localparam int CELL_W     = 8;
    localparam int SLOT_W     = 12;
    localparam int SLOTS      = 1 << SLOT_W;
    localparam int HEAD_W     = 17;
    localparam int COUNT_W    = 17;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indices.
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOUNDS_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INV_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INV_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INV_Z    = 3'd5;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_BINNED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SKIPPED = 2'd2;

    // Reset values and limits.
    localparam logic [INV_W-1:0]   INV_RESET  = 32'h0001_0000;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [HEAD_W-1:0]  HEAD_EMPTY = '1;

    // One classified request travelling from the front to the back.
    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [ID_W-1:0]   id;
        logic              last;
    } clb_item_t;

    // One entry of the cell store.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [HEAD_W-1:0]  head;
    } clb_entry_t;

endpackage

`default_nettype wire

FILE: sv/clb_front.sv
`default_nettype none

module clb_front
    import clb_pkg::*;
#(
    parameter int CELLS_X       = CELLS_X_DEF,
    parameter int CELLS_Y       = CELLS_Y_DEF,
    parameter int CELLS_Z       = CELLS_Z_DEF,
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic signed [POS_W-1:0] pos_z,
    input  wire logic [ID_W-1:0]       particle_id,
    input  wire logic                  last,
    input  wire logic [QCNT_W-1:0]     queue_count,
    input  wire logic                  clearing,
    output logic                       push,
    output clb_item_t                  push_item
);

    localparam int AXIS_SIZE [NUM_AXES] = '{CELLS_X, CELLS_Y, CELLS_Z};

    logic [BOUNDS_W-1:0] bounds_reg [NUM_AXES];
    logic [INV_W-1:0]    inv_reg    [NUM_AXES];
    logic [POS_W-1:0]    pos_in     [NUM_AXES];

    logic                accept;
    logic [QCNT_W-1:0]   in_flight;
    logic [POS_W:0]      diff_c   [NUM_AXES];
    logic [POS_W:0]      mag_c    [NUM_AXES];
    logic                above_c  [NUM_AXES];
    logic                id_ok_c;

    logic                v1_reg, v2_reg, v3_reg;
    logic [POS_W:0]      mag1_reg   [NUM_AXES];
    logic                neg1_reg   [NUM_AXES];
    logic                above1_reg [NUM_AXES];
    logic                id_ok1_reg;
    logic [ID_W-1:0]     id1_reg;
    logic                last1_reg;

    logic [63:0]         prod_c     [NUM_AXES];
    logic [31:0]         q2_reg     [NUM_AXES];
    logic                neg2_reg   [NUM_AXES];
    logic                above2_reg [NUM_AXES];
    logic                id_ok2_reg;
    logic [ID_W-1:0]     id2_reg;
    logic                last2_reg;

    logic                over_c [NUM_AXES];
    logic                bad_c  [NUM_AXES];
    logic [CELL_W-1:0]   cell_c [NUM_AXES];
    logic                ok_c;

    logic [CELL_W-1:0]   cell3_reg [NUM_AXES];
    logic                ok3_reg;
    logic [ID_W-1:0]     id3_reg;
    logic                last3_reg;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_AXES; a++)
            begin
                bounds_reg[a] <= '0;
                inv_reg[a]    <= INV_RESET;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_BOUNDS_X: bounds_reg[0] <= cfg_data;
                REG_BOUNDS_Y: bounds_reg[1] <= cfg_data;
                REG_BOUNDS_Z: bounds_reg[2] <= cfg_data;
                REG_INV_X:    inv_reg[0]    <= cfg_data[INV_W-1:0];
                REG_INV_Y:    inv_reg[1]    <= cfg_data[INV_W-1:0];
                REG_INV_Z:    inv_reg[2]    <= cfg_data[INV_W-1:0];
                default:      ;
            endcase
        end
    end

    // Stall while the store is cleared or when the queue could overflow.
    assign in_flight = QCNT_W'(v1_reg) + QCNT_W'(v2_reg) + QCNT_W'(v3_reg);
    assign in_stall  = clearing || ((queue_count + in_flight) >= QCNT_W'(QUEUE_DEPTH));
    assign accept    = in_valid && !in_stall;

    assign pos_in[0] = pos_x;
    assign pos_in[1] = pos_y;
    assign pos_in[2] = pos_z;

    // Offset from the lower bound, split into sign and magnitude.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            diff_c[a]  = {pos_in[a][POS_W-1], pos_in[a]}
                       - {bounds_reg[a][POS_W-1], bounds_reg[a][POS_W-1:0]};
            mag_c[a]   = diff_c[a][POS_W] ? (~diff_c[a] + 1'b1) : diff_c[a];
            above_c[a] = $signed(pos_in[a]) > $signed(bounds_reg[a][BOUNDS_W-1:POS_W]);
        end
        id_ok_c = {16'b0, particle_id} < 32'(MAX_PARTICLES);
    end

    // Scale by the reciprocal cell length; keep the integer part.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            prod_c[a] = 64'(mag1_reg[a]) * 64'(inv_reg[a]);
        end
    end

    // Range check and clamp per axis.
    always_comb
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            over_c[a] = !neg2_reg[a] && (q2_reg[a] > 32'(AXIS_SIZE[a] - 3));
            bad_c[a]  = (neg2_reg[a] && (q2_reg[a] != '0)) || (over_c[a] && above2_reg[a]);
            if (neg2_reg[a])
            begin
                cell_c[a] = CELL_W'(1);
            end
            else if (over_c[a])
            begin
                cell_c[a] = CELL_W'(AXIS_SIZE[a] - 2);
            end
            else
            begin
                cell_c[a] = q2_reg[a][CELL_W-1:0] + CELL_W'(1);
            end
        end
        ok_c = id_ok2_reg && !bad_c[0] && !bad_c[1] && !bad_c[2];
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge clk)
    begin
        for (int a = 0; a < NUM_AXES; a++)
        begin
            mag1_reg[a]   <= mag_c[a];
            neg1_reg[a]   <= diff_c[a][POS_W];
            above1_reg[a] <= above_c[a];
            q2_reg[a]     <= prod_c[a][63:32];
            neg2_reg[a]   <= neg1_reg[a];
            above2_reg[a] <= above1_reg[a];
            cell3_reg[a]  <= cell_c[a];
        end
        id_ok1_reg <= id_ok_c;
        id1_reg    <= particle_id;
        last1_reg  <= last;
        id_ok2_reg <= id_ok1_reg;
        id2_reg    <= id1_reg;
        last2_reg  <= last1_reg;
        ok3_reg    <= ok_c;
        id3_reg    <= id2_reg;
        last3_reg  <= last2_reg;
    end

    // Linear cell index, kept to the width of the store.
    assign push           = v3_reg;
    assign push_item.ok   = ok3_reg;
    assign push_item.slot = (SLOT_W'(cell3_reg[2]) * SLOT_W'(CELLS_Y) + SLOT_W'(cell3_reg[1]))
                          * SLOT_W'(CELLS_X) + SLOT_W'(cell3_reg[0]);
    assign push_item.id   = id3_reg;
    assign push_item.last = last3_reg;

endmodule

`default_nettype wire

FILE: sv/clb_queue.sv
`default_nettype none

module clb_queue
    import clb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire clb_item_t   push_item,
    input  wire logic        pop,
    output clb_item_t        head,
    output logic             empty,
    output logic [QCNT_W-1:0] count
);

    clb_item_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;

    // Pointers and fill level; the front never pushes into a full queue.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

endmodule

`default_nettype wire

FILE: sv/clb_back.sv
`default_nettype none

module clb_back
    import clb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire clb_item_t             head,
    input  wire logic                  q_empty,
    output logic                       pop,
    output logic                       clearing,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [SLOT_W-1:0]          cell_index,
    output logic signed [HEAD_W-1:0]   next_in_cell,
    output logic [STATUS_W-1:0]        status,
    output logic [ID_W-1:0]            id_out,
    output logic                       last_out
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_WRITE = 1'b1;

    clb_entry_t            cell_mem [SLOTS];
    clb_entry_t            rd_entry_reg;
    clb_entry_t            wr_entry;

    logic                  state_reg;
    logic                  state_next;
    logic                  clear_reg;
    logic [SLOT_W-1:0]     clr_cnt_reg;
    logic                  failed_reg;
    logic                  failed_next;

    logic [SLOT_W-1:0]     cur_slot_reg;
    logic [ID_W-1:0]       cur_id_reg;
    logic                  cur_last_reg;

    logic                  out_free;
    logic                  binned_pop;
    logic                  out_valid_reg;
    logic [SLOT_W-1:0]     cell_reg;
    logic [HEAD_W-1:0]     next_reg;
    logic [STATUS_W-1:0]   status_reg;
    logic [ID_W-1:0]       id_reg;
    logic                  last_reg;

    // Take a request when idle and the output register is free.
    assign out_free   = !out_valid_reg || !out_stall;
    assign pop        = !clear_reg && (state_reg == ST_IDLE) && !q_empty && out_free;
    assign binned_pop = pop && head.ok && !failed_reg;
    assign clearing   = clear_reg;

    // Error latch: set by a rejected request, cleared after a last mark.
    always_comb
    begin
        failed_next = failed_reg;
        if (pop)
        begin
            failed_next = head.last ? 1'b0 : (failed_reg || !head.ok);
        end
    end

    // Sequencer: a binned request reads its cell, then writes it back.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (binned_pop)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Updated entry: saturating count and the new list head.
    assign wr_entry.count = (rd_entry_reg.count == COUNT_MAX)
                          ? rd_entry_reg.count : rd_entry_reg.count + 1'b1;
    assign wr_entry.head  = {1'b0, cur_id_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clear_reg     <= 1'b1;
            clr_cnt_reg   <= '0;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            failed_reg <= failed_next;
            if (clear_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == '1)
                begin
                    clear_reg <= 1'b0;
                end
            end
            if ((pop && !binned_pop) || (state_reg == ST_WRITE))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Cell store: clearing pass after reset, then one read and one write port.
    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            cell_mem[clr_cnt_reg] <= '{count: '0, head: HEAD_EMPTY};
        end
        else if (state_reg == ST_WRITE)
        begin
            cell_mem[cur_slot_reg] <= wr_entry;
        end
        rd_entry_reg <= cell_mem[head.slot];
    end

    // Request held while its cell is read, and the result register.
    always_ff @(posedge clk)
    begin
        if (binned_pop)
        begin
            cur_slot_reg <= head.slot;
            cur_id_reg   <= head.id;
            cur_last_reg <= head.last;
        end
        if (pop && !binned_pop)
        begin
            cell_reg   <= '0;
            next_reg   <= '0;
            status_reg <= failed_reg ? STATUS_SKIPPED : STATUS_OUTSIDE;
            id_reg     <= head.id;
            last_reg   <= head.last;
        end
        else if (state_reg == ST_WRITE)
        begin
            cell_reg   <= cur_slot_reg;
            next_reg   <= rd_entry_reg.head;
            status_reg <= STATUS_BINNED;
            id_reg     <= cur_id_reg;
            last_reg   <= cur_last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_index   = cell_reg;
    assign next_in_cell = next_reg;
    assign status       = status_reg;
    assign id_out       = id_reg;
    assign last_out     = last_reg;

endmodule

`default_nettype wire

FILE: sv/cell_list_binning.sv
// Builds a linked cell list from a stream of particle positions. Each request carries a
// Q16.16 position, a particle index and a last mark; the block works out the cell on
// each axis, pushes the particle onto that cell's list and returns the linear cell
// index, the previous list head and a status. A rejected particle makes later ones
// report skipped until the end of the pass. The front classifies one request per cycle,
// while in_stall is low, through a three-stage pipeline into an eight-entry queue; the
// back handles a binned particle as a read of the cell store and then a write-back, and
// a rejected or skipped one in the idle state alone; it takes no new request during the
// write-back, set by the read-then-write on the single cell store. After reset every
// entry of the store is cleared, during which in_stall stays high; configuration writes
// are taken at any time and must only be made while the block is idle.

`default_nettype none

module cell_list_binning
    import clb_pkg::*;
#(
    parameter int CELLS_X       = CELLS_X_DEF,
    parameter int CELLS_Y       = CELLS_Y_DEF,
    parameter int CELLS_Z       = CELLS_Z_DEF,
    parameter int MAX_PARTICLES = MAX_PARTICLES_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [POS_W-1:0] pos_x,
    input  wire logic signed [POS_W-1:0] pos_y,
    input  wire logic signed [POS_W-1:0] pos_z,
    input  wire logic [ID_W-1:0]         particle_id,
    input  wire logic                    last,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [SLOT_W-1:0]            cell_index,
    output logic signed [HEAD_W-1:0]     next_in_cell,
    output logic [STATUS_W-1:0]          status,
    output logic [ID_W-1:0]              id_out,
    output logic                         last_out
);

    logic              push;
    clb_item_t         push_item;
    logic              pop;
    clb_item_t         head;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;
    logic              clearing;

    // Front: configuration and classification.
    clb_front #(
        .CELLS_X       (CELLS_X),
        .CELLS_Y       (CELLS_Y),
        .CELLS_Z       (CELLS_Z),
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .particle_id (particle_id),
        .last        (last),
        .queue_count (q_count),
        .clearing    (clearing),
        .push        (push),
        .push_item   (push_item)
    );

    // Queue between the two halves.
    clb_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .count     (q_count)
    );

    // Back: cell store update and results.
    clb_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .q_empty      (q_empty),
        .pop          (pop),
        .clearing     (clearing),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .cell_index   (cell_index),
        .next_in_cell (next_in_cell),
        .status       (status),
        .id_out       (id_out),
        .last_out     (last_out)
    );

endmodule

`default_nettype wire

FILE: sv/clb_checker.sv
`default_nettype none

module clb_checker
    import clb_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    out_valid,
    input  wire logic                    out_stall,
    input  wire logic [SLOT_W-1:0]       cell_index,
    input  wire logic signed [HEAD_W-1:0] next_in_cell,
    input  wire logic [STATUS_W-1:0]     status,
    input  wire logic [ID_W-1:0]         id_out,
    input  wire logic                    last_out
);

    // Only the three defined status codes are ever reported.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_BINNED || status == STATUS_OUTSIDE
                       || status == STATUS_SKIPPED))
    else $error("undefined status code on result");

    // A result that was not binned carries zero cell and successor.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_BINNED) |-> (cell_index == '0 && next_in_cell == '0))
    else $error("unbinned result with non-zero cell fields");

    // A negative successor can only be the empty-list mark.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_BINNED && next_in_cell[HEAD_W-1])
        |-> (next_in_cell == $signed(HEAD_EMPTY)))
    else $error("successor neither a particle index nor empty");

    // A stalled result stays and holds its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid
        && $stable({cell_index, next_in_cell, status, id_out, last_out})))
    else $error("stalled result dropped or changed");

endmodule

bind cell_list_binning clb_checker u_checker (.*);

`default_nettype wire

FILE: dv/binning_checker.sv
`default_nettype none

module binning_checker
    import clb_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic                  cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    input  wire logic                  in_stall,
    input  wire logic [POS_W-1:0]      pos_x,
    input  wire logic [POS_W-1:0]      pos_y,
    input  wire logic [POS_W-1:0]      pos_z,
    input  wire logic [ID_W-1:0]       particle_id,
    input  wire logic                  last,
    input  wire logic                  out_valid,
    input  wire logic                  out_stall,
    input  wire logic [SLOT_W-1:0]     cell_index,
    input  wire logic [HEAD_W-1:0]     next_in_cell,
    input  wire logic [STATUS_W-1:0]   status,
    input  wire logic [ID_W-1:0]       id_out,
    input  wire logic                  last_out,
    output int                         mismatches,
    output int                         pending
);

    // One result as the block should report it.
    typedef struct packed {
        logic [SLOT_W-1:0]   slot;
        logic [HEAD_W-1:0]   successor;
        logic [STATUS_W-1:0] stat;
        logic [ID_W-1:0]     id;
        logic                mark;
    } bin_result_t;

    // Shadow copy of the registers and of the cell store.
    logic [BOUNDS_W-1:0] domain_bounds [NUM_AXES];
    logic [INV_W-1:0]    cell_inv [NUM_AXES];
    logic [HEAD_W-1:0]   head_of [SLOTS];
    logic [COUNT_W-1:0]  occupancy [SLOTS];
    logic                skipping;

    bin_result_t expected_bins [$];
    bin_result_t want;
    bin_result_t got;

    // Cell along one axis: one plus the scaled offset from the lower bound, truncated
    // towards zero. The offset times the reciprocal is exact in 64 bits. Returns zero
    // when the particle lies outside the domain on this axis.
    function automatic bit axis_bin(input logic signed [POS_W-1:0] pos,
                                    input logic [BOUNDS_W-1:0] bounds,
                                    input logic [INV_W-1:0] inv,
                                    input int extent,
                                    output longint coord);
        logic signed [POS_W-1:0] lower;
        logic signed [POS_W-1:0] upper;
        longint                  offset;
        logic [63:0]             mag;
        logic [63:0]             quot;
        lower  = bounds[POS_W-1:0];
        upper  = bounds[BOUNDS_W-1:POS_W];
        offset = longint'(pos) - longint'(lower);
        mag    = (offset < 0) ? 64'(-offset) : 64'(offset);
        quot   = (mag * 64'(inv)) >> 32;
        coord  = (offset < 0) ? 1 - longint'(quot) : 1 + longint'(quot);
        if (coord < 1)
            return 1'b0;
        // Past the last inner cell: clamp if still inside the upper bound.
        if (coord > extent - 2)
        begin
            if (pos > upper)
                return 1'b0;
            coord = extent - 2;
        end
        return 1'b1;
    endfunction

    // Bins one particle against the shadow store and returns the result it causes.
    function automatic bin_result_t bin_particle(input logic [POS_W-1:0] px,
                                                 input logic [POS_W-1:0] py,
                                                 input logic [POS_W-1:0] pz,
                                                 input logic [ID_W-1:0] pid,
                                                 input logic pmark);
        bin_result_t       res;
        logic [POS_W-1:0]  pos [NUM_AXES];
        int                extent [NUM_AXES];
        longint            coord [NUM_AXES];
        logic [SLOT_W-1:0] slot;
        bit                in_domain;
        res       = '0;
        res.id    = pid;
        res.mark  = pmark;
        pos       = '{px, py, pz};
        extent    = '{CELLS_X_DEF, CELLS_Y_DEF, CELLS_Z_DEF};
        coord     = '{0, 0, 0};
        if (skipping)
        begin
            res.stat = STATUS_SKIPPED;
        end
        else
        begin
            in_domain = (int'(pid) < MAX_PARTICLES_DEF);
            // Axes are checked in order; the first failing one ends the check.
            for (int a = 0; a < NUM_AXES; a++)
            begin
                if (in_domain)
                    in_domain = axis_bin(pos[a], domain_bounds[a], cell_inv[a], extent[a],
                                         coord[a]);
            end
            if (in_domain)
            begin
                slot          = SLOT_W'((coord[2] * CELLS_Y_DEF + coord[1]) * CELLS_X_DEF
                                        + coord[0]);
                res.slot      = slot;
                res.successor = head_of[slot];
                res.stat      = STATUS_BINNED;
                if (occupancy[slot] != COUNT_MAX)
                    occupancy[slot] = occupancy[slot] + 1'b1;
                head_of[slot] = HEAD_W'(pid);
            end
            else
            begin
                skipping = 1'b1;
                res.stat = STATUS_OUTSIDE;
            end
        end
        // The end of a pass always clears the skip state.
        if (pmark)
            skipping = 1'b0;
        return res;
    endfunction

    task automatic flag(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                head_of[s]   = HEAD_EMPTY;
                occupancy[s] = '0;
            end
            for (int a = 0; a < NUM_AXES; a++)
            begin
                domain_bounds[a] = '0;
                cell_inv[a]      = INV_RESET;
            end
            skipping = 1'b0;
            expected_bins.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            // Register writes; only made while the block is idle.
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_BOUNDS_X: domain_bounds[0] = cfg_data;
                    REG_BOUNDS_Y: domain_bounds[1] = cfg_data;
                    REG_BOUNDS_Z: domain_bounds[2] = cfg_data;
                    REG_INV_X:    cell_inv[0] = cfg_data[INV_W-1:0];
                    REG_INV_Y:    cell_inv[1] = cfg_data[INV_W-1:0];
                    REG_INV_Z:    cell_inv[2] = cfg_data[INV_W-1:0];
                    default:      ;
                endcase
            end

            // Results are compared in order against the oldest prediction.
            if (out_valid && !out_stall)
            begin
                got = '{cell_index, next_in_cell, status, id_out, last_out};
                if (expected_bins.size() == 0)
                begin
                    flag($sformatf({"result with no request outstanding: slot %0d next %0d",
                                    " status %0d id %0d last %0b"},
                                   got.slot, $signed(got.successor), got.stat, got.id,
                                   got.mark));
                end
                else
                begin
                    want = expected_bins.pop_front();
                    if (got.slot !== want.slot || got.successor !== want.successor ||
                        got.stat !== want.stat || got.id !== want.id || got.mark !== want.mark)
                        flag($sformatf({"mismatch: expected slot %0d next %0d status %0d",
                                        " id %0d last %0b, got slot %0d next %0d",
                                        " status %0d id %0d last %0b"},
                                       want.slot, $signed(want.successor), want.stat, want.id,
                                       want.mark, got.slot, $signed(got.successor), got.stat,
                                       got.id, got.mark));
                end
            end

            // Each accepted request is predicted at once.
            if (in_valid && !in_stall)
                expected_bins.push_back(bin_particle(pos_x, pos_y, pos_z, particle_id, last));

            pending = expected_bins.size();
        end
    end

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`default_nettype none

module testbench;
    import clb_pkg::*;

    localparam logic [POS_W-1:0] ONE            = 32'h0001_0000;
    localparam int               DRAIN_CYCLES   = 32;
    localparam int               TIMEOUT_CYCLES = 250_000;
    localparam int               PHASES         = 6;
    localparam int               PHASE_ITEMS    = 310;

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        cfg_valid;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index;
    logic [CFG_DATA_W-1:0]       cfg_data;
    logic                        in_valid;
    logic                        in_stall;
    logic signed [POS_W-1:0]     pos_x;
    logic signed [POS_W-1:0]     pos_y;
    logic signed [POS_W-1:0]     pos_z;
    logic [ID_W-1:0]             particle_id;
    logic                        last;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [SLOT_W-1:0]           cell_index;
    logic signed [HEAD_W-1:0]    next_in_cell;
    logic [STATUS_W-1:0]         status;
    logic [ID_W-1:0]             id_out;
    logic                        last_out;
    int                          mismatches;
    int                          pending;

    int                          send_idle_pct  = 12;
    int                          recv_stall_pct = 60;
    int                          cycle_count    = 0;

    // Domain currently programmed, kept here to aim the random positions.
    logic [BOUNDS_W-1:0]         bounds_cfg [NUM_AXES];
    logic [INV_W-1:0]            inv_cfg [NUM_AXES];

    cell_list_binning dut (.*);

    binning_checker u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Random back-pressure on the result side.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= TIMEOUT_CYCLES);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Fifteen cell lengths for a given reciprocal, capped so that sums stay in range.
    function automatic logic [POS_W-1:0] cell_span(input logic [INV_W-1:0] inv);
        logic [63:0] wide;
        wide = (inv == '0) ? 64'h2000_0000 : (64'd15 << 32) / 64'(inv);
        return (wide > 64'h2000_0000) ? 32'h2000_0000 : wide[31:0];
    endfunction

    // Offers one request, with a random gap before it, and waits until it is taken.
    task automatic send_particle(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                 input logic [POS_W-1:0] z, input logic [ID_W-1:0] pid,
                                 input logic mark);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        pos_x       <= x;
        pos_y       <= y;
        pos_z       <= z;
        particle_id <= pid;
        last        <= mark;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Holds off new requests until every result is back and the pipeline is quiet.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic program_domain();
        write_reg(REG_BOUNDS_X, bounds_cfg[0]);
        write_reg(REG_BOUNDS_Y, bounds_cfg[1]);
        write_reg(REG_BOUNDS_Z, bounds_cfg[2]);
        write_reg(REG_INV_X, CFG_DATA_W'(inv_cfg[0]));
        write_reg(REG_INV_Y, CFG_DATA_W'(inv_cfg[1]));
        write_reg(REG_INV_Z, CFG_DATA_W'(inv_cfg[2]));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [POS_W-1:0] lower;
        logic [POS_W-1:0] upper;
        logic [POS_W-1:0] span;
        logic [POS_W-1:0] coord [NUM_AXES];
        logic [ID_W-1:0]  base;
        int               sent;
        int               len;
        int               noisy_axis;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = REG_BOUNDS_X;
        cfg_data    = '0;
        in_valid    = 1'b0;
        pos_x       = '0;
        pos_y       = '0;
        pos_z       = '0;
        particle_id = '0;
        last        = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests against the reset domain: bounds zero, unit cells.
        send_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd0, 1'b0);
        send_particle(ONE / 2, ONE / 4, 32'h0000_0003, 16'd1, 1'b0);
        // Just below the lower bound still truncates into the first cell.
        send_particle(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd2, 1'b0);
        send_particle(32'h000D_FFFF, 32'h0000_0000, 32'h0000_0000, 16'd3, 1'b0);
        // Past the last cell and above the upper bound; the pass then skips.
        send_particle(32'h000E_0000, 32'h0000_0000, 32'h0000_0000, 16'd4, 1'b0);
        send_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd5, 1'b0);
        send_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd6, 1'b1);
        // Error on the z axis only, on the last particle of its pass.
        send_particle(32'h0000_0000, 32'h0000_0000, 32'hFFFF_0000, 16'd7, 1'b1);
        send_particle(32'h0000_0000, 32'h8000_0000, 32'h0000_0000, 16'd8, 1'b0);
        send_particle(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd9, 1'b1);
        send_particle(32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_0000, 16'd10, 1'b0);
        send_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b1);
        send_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'hFFFF, 1'b0);
        send_particle(ONE * 5, ONE * 7, ONE * 9, 16'hA5A5, 1'b1);

        // Bounds of -8.0 and 8.0, with cells of 1.0, 0.5 and 2.0.
        wait_drain();
        for (int a = 0; a < NUM_AXES; a++)
            bounds_cfg[a] = {32'h0008_0000, 32'hFFF8_0000};
        inv_cfg = '{32'h0001_0000, 32'h0002_0000, 32'h0000_8000};
        program_domain();
        // Clamped into the last inner cell on x and y.
        send_particle(32'h0008_0000, 32'h0000_0000, 32'hFFF8_0000, 16'd20, 1'b0);
        send_particle(32'h0008_0001, 32'h0000_0000, 32'h0000_0000, 16'd21, 1'b0);
        send_particle(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 16'd22, 1'b1);
        send_particle(32'hFFF7_FFFF, 32'h0000_0000, 32'h0000_0000, 16'd23, 1'b0);
        send_particle(32'hFFF7_0000, 32'h0000_0000, 32'h0000_0000, 16'd24, 1'b1);
        send_particle(32'h0000_0000, 32'hFFF7_8000, 32'h0000_0000, 16'd25, 1'b1);
        send_particle(32'h0000_0000, 32'h0000_0000, 32'h0008_0000, 16'd26, 1'b1);

        // Random passes, each phase under a domain of its own.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            send_idle_pct  = (phase < 2) ? 12 : (phase < 4) ? 60 : 0;
            recv_stall_pct = (phase < 2) ? 60 : (phase < 4) ? 12 : 0;
            wait_drain();
            for (int a = 0; a < NUM_AXES; a++)
            begin
                case (phase)
                    // Widest bounds with the finest cells.
                    1:
                    begin
                        bounds_cfg[a] = {32'h7FFF_FFFF, 32'h8000_0000};
                        inv_cfg[a]    = '1;
                    end
                    // Zero reciprocal: every particle lands in the first cell.
                    3:
                    begin
                        bounds_cfg[a] = '1;
                        inv_cfg[a]    = '0;
                    end
                    default:
                    begin
                        lower      = 32'($urandom_range(32'h7FFF_FFFF)) - 32'h4000_0000;
                        inv_cfg[a] = ($urandom_range(3) == 0) ? 32'($urandom())
                                   : 32'($urandom_range(32'h0010_0000, 32'h0000_1000));
                        span       = cell_span(inv_cfg[a]);
                        upper      = lower + (($urandom_range(1) == 0)
                                              ? $urandom_range(span + span / 15)
                                              : $urandom_range(32'h2000_0000));
                        bounds_cfg[a] = {upper, lower};
                    end
                endcase
            end
            program_domain();

            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                len  = $urandom_range(24, 1);
                base = ($urandom_range(3) == 0) ? ID_W'($urandom()) : '0;
                for (int k = 0; k < len && sent < PHASE_ITEMS; k++)
                begin
                    // Mostly positions inside the grid; now and then one axis is off.
                    noisy_axis = ($urandom_range(99) < 10) ? $urandom_range(NUM_AXES - 1)
                                                           : NUM_AXES;
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        lower = bounds_cfg[a][POS_W-1:0];
                        upper = bounds_cfg[a][BOUNDS_W-1:POS_W];
                        span  = cell_span(inv_cfg[a]);
                        if (a == noisy_axis)
                        begin
                            case ($urandom_range(4))
                                0:       coord[a] = $urandom();
                                1:       coord[a] = lower;
                                2:       coord[a] = upper;
                                3:       coord[a] = upper + 1;
                                default: coord[a] = lower - 1;
                            endcase
                        end
                        else
                        begin
                            coord[a] = lower + $urandom_range(span) - span / 14;
                        end
                    end
                    send_particle(coord[0], coord[1], coord[2], base + ID_W'(k),
                                  (k == len - 1) || (sent == PHASE_ITEMS - 1));
                    sent++;
                end
            end
        end

        wait_drain();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
sv/clb_pkg.sv
sv/clb_front.sv
sv/clb_queue.sv
sv/clb_back.sv
sv/cell_list_binning.sv
sv/clb_checker.sv
dv/binning_checker.sv
dv/testbench.sv
